/* design/lre_pkg.sv */
`default_nettype none

package lre_pkg;

  // probability model
  localparam int unsigned PROB_BITS  = 11;
  localparam int unsigned MOVE_BITS  = 5;
  localparam logic [PROB_BITS-1:0] PROB_INIT = 11'd1024;
  localparam logic [PROB_BITS:0]   PROB_ONE  = 12'd2048;

  // literal tree, entry 0 unused by the tree and holds the is-match probability
  localparam int unsigned LIT_CTX   = 256;
  localparam int unsigned CTX_BITS  = $clog2(LIT_CTX);
  localparam logic [CTX_BITS-1:0] MATCH_CTX = '0;
  localparam logic [CTX_BITS-1:0] TREE_ROOT = 8'd1;

  // range coder
  localparam logic [31:0] RANGE_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] TOP_VALUE  = 32'h0100_0000;
  localparam logic [7:0]  FILL_NOCARRY = 8'hFF;
  localparam logic [7:0]  FILL_CARRY   = 8'h00;
  localparam int unsigned PENDING_WIDTH_DEF = 16;
  localparam int unsigned COUNT_BITS = 16;

  // nine coded bits per byte, five shifts per finish
  localparam logic [3:0] LAST_BIT = 4'd8;
  localparam logic [2:0] LAST_FIN = 3'd4;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef struct packed {
    logic [7:0]            head;
    logic [COUNT_BITS-1:0] count;
    logic [7:0]            fill;
    logic                  ovf;
  } res_t;

endpackage

`default_nettype wire

/* design/lzma_literal_range_encoder.sv */
`default_nettype none

// channel | direction | words per item      | payload
// in      | sink      | 1                   | command_i, byte_value_i
// out     | source    | 0 to 9 (5 max fin.) | head_byte_o, fill_count_o, fill_value_o,
//         |           |                     | last_o, pending_overflow_o
//
// an encode item steps, when nothing stalls, through: accept and read the is-match
// probability, then a multiply step and an update step with write-back for each of
// the nine coded bits, then release of the last word
// a finish item steps through accept, five shifts of low, release of the last word
// rst_ni clears only the control and coder state; per-entry valid bits stand for the
// probability reset, so no clearing pass is needed; a finish clears them the same way
// a word waiting in the output register stalls the update and shift steps until taken

module lzma_literal_range_encoder #(
  parameter int unsigned PENDING_WIDTH = lre_pkg::PENDING_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [7:0]  byte_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       head_byte_o,
  output logic [lre_pkg::COUNT_BITS-1:0] fill_count_o,
  output logic [7:0]       fill_value_o,
  output logic             last_o,
  output logic             pending_overflow_o
);
  import lre_pkg::*;

  // control and coder state
  state_e                 state_q, state_d;
  logic [32:0]            low_q, low_d;
  logic [31:0]            range_q, range_d;
  logic [7:0]             cache_q, cache_d;
  logic [PENDING_WIDTH-1:0] pend_q, pend_d;
  logic                   sticky_q, sticky_d;
  logic [LIT_CTX-1:0]     pvalid_q, pvalid_d;
  logic [CTX_BITS-1:0]    ctx_q, ctx_d;
  logic [3:0]             bitcnt_q, bitcnt_d;
  logic [2:0]             fin_cnt_q, fin_cnt_d;
  logic                   rd_vld_q, rd_vld_d;
  logic                   hold_vld_q, hold_vld_d;
  logic                   out_vld_q, out_vld_d;

  // payload registers
  logic [7:0]             byte_q, byte_d;
  logic [PROB_BITS-1:0]   prob_q, prob_d;
  logic [31:0]            bound_q, bound_d;
  logic [PROB_BITS-1:0]   rd_data_q;
  res_t                   hold_q;
  res_t                   out_q;
  logic                   out_last_q;

  // probability memory, one synchronous read and one write port
  logic [PROB_BITS-1:0]   prob_mem [LIT_CTX];

  logic                   accept, can_push;
  logic                   cur_bit;
  logic [PROB_BITS-1:0]   prob_in, p_up, p_dn, prob_new;
  logic [31:0]            mul_prod;
  logic [32:0]            low_bit;
  logic [31:0]            range_bit;
  logic                   need_norm;
  logic [32:0]            sh_in, sh_low;
  logic                   sh_carry, sh_flush;
  res_t                   emit_res;
  logic                   shift_now, fin_clear;
  logic                   push, push_last, hold_load;
  logic                   mem_we, rd_en;
  logic [CTX_BITS-1:0]    rd_addr;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign can_push   = !out_vld_q || out_ready_i;

  // the is-match bit is always zero, literal bits go msb first
  assign cur_bit = (bitcnt_q == 4'd0) ? 1'b0 : byte_q[7];

  // unwritten entries read as the reset probability
  assign prob_in  = rd_vld_q ? rd_data_q : PROB_INIT;
  assign mul_prod = range_q[31:11] * prob_in;

  // probability adaption
  assign p_up = prob_q + PROB_BITS'((PROB_ONE - {1'b0, prob_q}) >> MOVE_BITS);
  assign p_dn = prob_q - (prob_q >> MOVE_BITS);

  always_comb begin
    if (cur_bit) begin
      low_bit   = low_q + {1'b0, bound_q};
      range_bit = range_q - bound_q;
      prob_new  = p_dn;
    end else begin
      low_bit   = low_q;
      range_bit = bound_q;
      prob_new  = p_up;
    end
  end

  assign need_norm = (range_bit < TOP_VALUE);

  // shift of low: either flushes the cached byte with its run of fill bytes
  // or grows the pending run, which saturates and then sets the sticky overflow
  assign sh_in    = (state_q == ST_FIN) ? low_q : low_bit;
  assign sh_carry = sh_in[32];
  assign sh_flush = sh_carry || (sh_in[31:24] != 8'hFF);
  assign sh_low   = {1'b0, sh_in[23:0], 8'h00};

  always_comb begin
    emit_res.head  = cache_q + {7'd0, sh_carry};
    emit_res.count = COUNT_BITS'(pend_q - PENDING_WIDTH'(1));
    emit_res.fill  = sh_carry ? FILL_CARRY : FILL_NOCARRY;
    emit_res.ovf   = sticky_q;
  end

  always_comb begin
    state_d    = state_q;
    low_d      = low_q;
    range_d    = range_q;
    cache_d    = cache_q;
    pend_d     = pend_q;
    sticky_d   = sticky_q;
    pvalid_d   = pvalid_q;
    ctx_d      = ctx_q;
    bitcnt_d   = bitcnt_q;
    fin_cnt_d  = fin_cnt_q;
    rd_vld_d   = rd_vld_q;
    hold_vld_d = hold_vld_q;
    out_vld_d  = out_vld_q;
    byte_d     = byte_q;
    prob_d     = prob_q;
    bound_d    = bound_q;
    shift_now  = 1'b0;
    fin_clear  = 1'b0;
    push       = 1'b0;
    push_last  = 1'b0;
    hold_load  = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = MATCH_CTX;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_FINISH) begin
            fin_cnt_d = '0;
            state_d   = ST_FIN;
          end else begin
            byte_d   = byte_value_i;
            ctx_d    = MATCH_CTX;
            bitcnt_d = '0;
            rd_en    = 1'b1;
            rd_addr  = MATCH_CTX;
            state_d  = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prob_d  = prob_in;
        bound_d = mul_prod;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (can_push) begin
          mem_we          = 1'b1;
          pvalid_d[ctx_q] = 1'b1;
          if (need_norm) begin
            range_d   = {range_bit[23:0], 8'h00};
            low_d     = sh_low;
            shift_now = 1'b1;
          end else begin
            range_d = range_bit;
            low_d   = low_bit;
          end
          if (bitcnt_q == 4'd0) begin
            ctx_d = TREE_ROOT;
          end else begin
            ctx_d  = {ctx_q[CTX_BITS-2:0], cur_bit};
            byte_d = {byte_q[6:0], 1'b0};
          end
          bitcnt_d = bitcnt_q + 4'd1;
          if (bitcnt_q == LAST_BIT) begin
            state_d = ST_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ctx_d;
            state_d = ST_MUL;
          end
        end
      end
      ST_FIN: begin
        if (can_push) begin
          low_d     = sh_low;
          shift_now = 1'b1;
          fin_cnt_d = fin_cnt_q + 3'd1;
          if (fin_cnt_q == LAST_FIN) begin
            fin_clear = 1'b1;
            state_d   = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!hold_vld_q) begin
          state_d = ST_IDLE;
        end else if (can_push) begin
          push       = 1'b1;
          push_last  = 1'b1;
          hold_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (rd_en) begin
      rd_vld_d = pvalid_q[rd_addr];
    end

    // the newest word stays in the hold register until it is known whether it is last
    if (shift_now) begin
      if (sh_flush) begin
        if (hold_vld_q) begin
          push = 1'b1;
        end
        hold_load  = 1'b1;
        hold_vld_d = 1'b1;
        cache_d    = sh_in[31:24];
        pend_d     = PENDING_WIDTH'(1);
      end else if (pend_q == '1) begin
        sticky_d = 1'b1;
      end else begin
        pend_d = pend_q + PENDING_WIDTH'(1);
      end
    end

    // end of stream returns the coder to its reset state
    if (fin_clear) begin
      low_d    = '0;
      range_d  = RANGE_INIT;
      cache_d  = '0;
      pend_d   = PENDING_WIDTH'(1);
      sticky_d = 1'b0;
      pvalid_d = '0;
    end

    if (push) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      low_q      <= '0;
      range_q    <= RANGE_INIT;
      cache_q    <= '0;
      pend_q     <= PENDING_WIDTH'(1);
      sticky_q   <= 1'b0;
      pvalid_q   <= '0;
      ctx_q      <= '0;
      bitcnt_q   <= '0;
      fin_cnt_q  <= '0;
      rd_vld_q   <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      low_q      <= low_d;
      range_q    <= range_d;
      cache_q    <= cache_d;
      pend_q     <= pend_d;
      sticky_q   <= sticky_d;
      pvalid_q   <= pvalid_d;
      ctx_q      <= ctx_d;
      bitcnt_q   <= bitcnt_d;
      fin_cnt_q  <= fin_cnt_d;
      rd_vld_q   <= rd_vld_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    prob_q  <= prob_d;
    bound_q <= bound_d;
    if (hold_load) begin
      hold_q <= emit_res;
    end
    if (push) begin
      out_q      <= hold_q;
      out_last_q <= push_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prob_mem[ctx_q] <= prob_new;
    end
    if (rd_en) begin
      rd_data_q <= prob_mem[rd_addr];
    end
  end

  assign out_valid_o        = out_vld_q;
  assign head_byte_o        = out_q.head;
  assign fill_count_o       = out_q.count;
  assign fill_value_o       = out_q.fill;
  assign pending_overflow_o = out_q.ovf;
  assign last_o             = out_last_q;

endmodule

`default_nettype wire

/* design/lre_checker.sv */
`default_nettype none

module lre_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  head_byte_o,
  input wire logic [15:0] fill_count_o,
  input wire logic [7:0]  fill_value_o,
  input wire logic        last_o,
  input wire logic        pending_overflow_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(head_byte_o)
      && $stable(fill_count_o) && $stable(fill_value_o) && $stable(last_o)
      && $stable(pending_overflow_o))
    else $error("output word changed while stalled");

  // fill bytes are all ones, or all zeros after a carry
  a_fill_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_value_o == 8'hFF || fill_value_o == 8'h00)
    else $error("bad fill value");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // once idle, any word still waiting closes its item
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> last_o)
    else $error("idle with a non-final word outstanding");

endmodule

bind lzma_literal_range_encoder lre_checker u_lre_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .head_byte_o        (head_byte_o),
  .fill_count_o       (fill_count_o),
  .fill_value_o       (fill_value_o),
  .last_o             (last_o),
  .pending_overflow_o (pending_overflow_o)
);

`default_nettype wire
